FILE: rtl/core/swfd_pkg.sv
package swfd_pkg;

    localparam int MAX_WORDS      = 16;
    localparam int RING_DEPTH     = 64;
    localparam int RING_AW        = $clog2(RING_DEPTH);
    localparam int CFG_W          = 5;
    localparam int CNT_W          = $clog2(MAX_WORDS + 1);
    localparam int WIDX_W         = 4;
    localparam int FRAME_OVERHEAD = 9;
    localparam int FRAME_MAX      = FRAME_OVERHEAD + 2 * MAX_WORDS;
    localparam int FS_W           = $clog2(FRAME_MAX + 1);

    // byte positions inside a frame
    localparam int POS_SIZE  = 2;
    localparam int POS_ADDR  = 3;
    localparam int POS_TYPE  = 4;
    localparam int WORD_BASE = 5;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  FRAME_TYPE = 8'h01;
    localparam logic [7:0]  MARKER     = 8'h00;
    localparam logic [7:0]  RING_FILL  = 8'hFF;
    localparam logic [CFG_W-1:0] WORD_COUNT_RESET = 5'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_WLO,
        ST_WHI,
        ST_WGET,
        ST_OUT
    } swfd_state_t;

endpackage

FILE: rtl/core/swfd_ram.sv
module swfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/swfd_crc_unit.sv
module swfd_crc_unit (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);

    logic [15:0] c;

    // one byte of CRC-16, MSB first
    always_comb
    begin
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ swfd_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

FILE: rtl/core/sliding_window_frame_detector_unit.sv
// Sliding-window frame detector.
// Input channel: in_valid / in_stall / rx_byte. Each accepted byte is written into a
// 64-entry byte ring, then the newest 9 + 2*n bytes (n = word_count, capped at 16)
// are scanned as one frame: zero markers, size byte, type 0x01, CRC-16 and trailer.
// Output channel: out_valid / out_stall and the result fields. A good frame gives one
// transaction per data word (or one with has_word 0 when n is 0); anything else gives
// a single failure transaction. The final transaction of a byte carries last.
// Timing: the scan reads one ring byte per cycle through the single RAM read port
// and the byte-wide CRC unit. Each data word then takes two RAM reads, a load and a
// hand-over; a single result is loaded and handed over directly. in_stall is high
// from acceptance until the last transaction leaves. When out_stall is high the
// result holds in the output register and the sequencer waits.
// Configuration: cfg_we writes cfg_wdata into word_count; write only while idle.
// Reset: ring reads back 0xFF (per-entry valid bits cleared), write pointer 0,
// word_count 1. No clearing pass is needed.
module sliding_window_frame_detector_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        frame_found,
    output logic [7:0]                  frame_address,
    output logic                        has_word,
    output logic [swfd_pkg::WIDX_W-1:0] word_index,
    output logic [15:0]                 data_word,
    output logic                        last,
    input  logic                        cfg_we,
    input  logic [swfd_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int AW   = swfd_pkg::RING_AW;
    localparam int FSW  = swfd_pkg::FS_W;
    localparam int CW   = swfd_pkg::CNT_W;
    localparam int WIW  = swfd_pkg::WIDX_W;

    swfd_pkg::swfd_state_t state_reg, state_next;

    logic [swfd_pkg::CFG_W-1:0]      word_count_reg;
    logic [AW-1:0]                   wp_reg, wp_next;
    logic [swfd_pkg::RING_DEPTH-1:0] ring_valid_reg, ring_valid_next;
    logic [AW-1:0]                   start_reg, start_next;
    logic [CW-1:0]                   n_reg, n_next;
    logic [FSW-1:0]                  fsize_reg, fsize_next;
    logic [FSW-1:0]                  issue_reg, issue_next;
    logic [FSW-1:0]                  scan_j_reg, scan_j_next;
    logic                            scan_pend_reg, scan_pend_next;
    logic                            ok_reg, ok_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [15:0]                     rxcrc_reg, rxcrc_next;
    logic [7:0]                      addr_reg, addr_next;
    logic [7:0]                      lo_reg, lo_next;
    logic [WIW-1:0]                  word_i_reg, word_i_next;
    logic                            rd_valid_reg;

    logic                            found_reg, found_next;
    logic [7:0]                      faddr_reg, faddr_next;
    logic                            has_word_reg, has_word_next;
    logic [WIW-1:0]                  widx_reg, widx_next;
    logic [15:0]                     data_reg, data_next;
    logic                            last_reg, last_next;

    logic                            accept;
    logic                            ram_we;
    logic [AW-1:0]                   ram_raddr;
    logic [7:0]                      ram_rdata;
    logic [7:0]                      rd_byte;
    logic [15:0]                     crc_step;
    logic [CW-1:0]                   n_cap;
    logic [FSW-1:0]                  fsize_cap;
    logic [FSW-1:0]                  word_off;
    logic                            match;
    logic                            word_last;

    assign accept = in_valid && !in_stall;
    assign ram_we = accept;

    swfd_ram #(
        .WIDTH (8),
        .DEPTH (swfd_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written entries read as the reset fill
    assign rd_byte = rd_valid_reg ? ram_rdata : swfd_pkg::RING_FILL;

    swfd_crc_unit u_crc (
        .crc_in  (crc_reg),
        .data_in (rd_byte),
        .crc_out (crc_step)
    );

    always_comb
    begin
        if (int'(word_count_reg) > swfd_pkg::MAX_WORDS)
        begin
            n_cap = CW'(swfd_pkg::MAX_WORDS);
        end
        else
        begin
            n_cap = CW'(word_count_reg);
        end
        fsize_cap = FSW'(swfd_pkg::FRAME_OVERHEAD) + FSW'({n_cap, 1'b0});
    end

    assign word_off  = FSW'(swfd_pkg::WORD_BASE) + FSW'({word_i_reg, 1'b0});
    assign match     = ok_reg && (crc_reg == rxcrc_reg);
    assign word_last = (CW'(word_i_reg) + CW'(1)) == n_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swfd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = swfd_pkg::ST_SCAN;
                end
            end
            swfd_pkg::ST_SCAN:
            begin
                if (issue_reg == fsize_reg - FSW'(1))
                begin
                    state_next = swfd_pkg::ST_DRAIN;
                end
            end
            swfd_pkg::ST_DRAIN:
            begin
                state_next = swfd_pkg::ST_DECIDE;
            end
            swfd_pkg::ST_DECIDE:
            begin
                if (!match || n_reg == '0)
                begin
                    state_next = swfd_pkg::ST_OUT;
                end
                else
                begin
                    state_next = swfd_pkg::ST_WLO;
                end
            end
            swfd_pkg::ST_WLO:
            begin
                state_next = swfd_pkg::ST_WHI;
            end
            swfd_pkg::ST_WHI:
            begin
                state_next = swfd_pkg::ST_WGET;
            end
            swfd_pkg::ST_WGET:
            begin
                state_next = swfd_pkg::ST_OUT;
            end
            swfd_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = last_reg ? swfd_pkg::ST_IDLE : swfd_pkg::ST_WLO;
                end
            end
            default:
            begin
                state_next = swfd_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        ram_raddr = start_reg;
        unique case (state_reg)
            swfd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            swfd_pkg::ST_SCAN:
            begin
                ram_raddr = start_reg + AW'(issue_reg);
            end
            swfd_pkg::ST_WLO:
            begin
                ram_raddr = start_reg + AW'(word_off);
            end
            swfd_pkg::ST_WHI:
            begin
                ram_raddr = start_reg + AW'(word_off) + AW'(1);
            end
            swfd_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        wp_next         = wp_reg;
        ring_valid_next = ring_valid_reg;
        start_next      = start_reg;
        n_next          = n_reg;
        fsize_next      = fsize_reg;
        issue_next      = issue_reg;
        scan_pend_next  = (state_reg == swfd_pkg::ST_SCAN);
        scan_j_next     = issue_reg;
        ok_next         = ok_reg;
        crc_next        = crc_reg;
        rxcrc_next      = rxcrc_reg;
        addr_next       = addr_reg;
        lo_next         = lo_reg;
        word_i_next     = word_i_reg;
        found_next      = found_reg;
        faddr_next      = faddr_reg;
        has_word_next   = has_word_reg;
        widx_next       = widx_reg;
        data_next       = data_reg;
        last_next       = last_reg;

        if (accept)
        begin
            ring_valid_next[wp_reg] = 1'b1;
            wp_next     = wp_reg + AW'(1);
            n_next      = n_cap;
            fsize_next  = fsize_cap;
            start_next  = wp_reg + AW'(1) - AW'(fsize_cap);
            issue_next  = '0;
            ok_next     = 1'b1;
            crc_next    = swfd_pkg::CRC_INIT;
            word_i_next = '0;
        end

        if (state_reg == swfd_pkg::ST_SCAN)
        begin
            issue_next = issue_reg + FSW'(1);
        end

        // check the byte that came back from the ring
        if (scan_pend_reg)
        begin
            if (scan_j_reg == FSW'(0) || scan_j_reg == FSW'(1) ||
                scan_j_reg == fsize_reg - FSW'(2) || scan_j_reg == fsize_reg - FSW'(1))
            begin
                if (rd_byte != swfd_pkg::MARKER)
                begin
                    ok_next = 1'b0;
                end
            end
            if (scan_j_reg == FSW'(swfd_pkg::POS_SIZE) && rd_byte != 8'(fsize_reg))
            begin
                ok_next = 1'b0;
            end
            if (scan_j_reg == FSW'(swfd_pkg::POS_TYPE) && rd_byte != swfd_pkg::FRAME_TYPE)
            begin
                ok_next = 1'b0;
            end
            if (scan_j_reg == FSW'(swfd_pkg::POS_ADDR))
            begin
                addr_next = rd_byte;
            end
            if (scan_j_reg < fsize_reg - FSW'(4))
            begin
                crc_next = crc_step;
            end
            if (scan_j_reg == fsize_reg - FSW'(4))
            begin
                rxcrc_next[7:0] = rd_byte;
            end
            if (scan_j_reg == fsize_reg - FSW'(3))
            begin
                rxcrc_next[15:8] = rd_byte;
            end
        end

        case (state_reg)
            swfd_pkg::ST_DECIDE:
            begin
                found_next    = match;
                faddr_next    = match ? addr_reg : 8'h00;
                has_word_next = 1'b0;
                widx_next     = '0;
                data_next     = 16'h0000;
                last_next     = 1'b1;
            end
            swfd_pkg::ST_WHI:
            begin
                lo_next = rd_byte;
            end
            swfd_pkg::ST_WGET:
            begin
                found_next    = 1'b1;
                faddr_next    = addr_reg;
                has_word_next = 1'b1;
                widx_next     = word_i_reg;
                data_next     = {rd_byte, lo_reg};
                last_next     = word_last;
            end
            swfd_pkg::ST_OUT:
            begin
                if (!out_stall && !last_reg)
                begin
                    word_i_next = word_i_reg + WIW'(1);
                end
            end
            default:
            begin
                lo_next = lo_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= swfd_pkg::ST_IDLE;
            word_count_reg <= swfd_pkg::WORD_COUNT_RESET;
            wp_reg         <= '0;
            ring_valid_reg <= '0;
            scan_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            ring_valid_reg <= ring_valid_next;
            scan_pend_reg  <= scan_pend_next;
            if (cfg_we)
            begin
                word_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_valid_reg <= ring_valid_reg[ram_raddr];
        start_reg    <= start_next;
        n_reg        <= n_next;
        fsize_reg    <= fsize_next;
        issue_reg    <= issue_next;
        scan_j_reg   <= scan_j_next;
        ok_reg       <= ok_next;
        crc_reg      <= crc_next;
        rxcrc_reg    <= rxcrc_next;
        addr_reg     <= addr_next;
        lo_reg       <= lo_next;
        word_i_reg   <= word_i_next;
        found_reg    <= found_next;
        faddr_reg    <= faddr_next;
        has_word_reg <= has_word_next;
        widx_reg     <= widx_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
    end

    assign frame_found   = found_reg;
    assign frame_address = faddr_reg;
    assign has_word      = has_word_reg;
    assign word_index    = widx_reg;
    assign data_word     = data_reg;
    assign last          = last_reg;

    // a byte's results never overlap the next acceptance
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while previous byte in progress");

    a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_found) |-> (last && !has_word && frame_address == 8'h00))
        else $error("failure transaction malformed");

    a_word_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_word) |-> frame_found)
        else $error("data word without a frame");

    a_out_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> (!out_valid && !in_stall))
        else $error("extra transaction after last");

endmodule

FILE: verif/sliding_window_frame_detector_unit_tb.sv
module sliding_window_frame_detector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swfd_pkg::*;

    typedef struct packed {
        logic              frame_found;
        logic [7:0]        frame_address;
        logic              has_word;
        logic [WIDX_W-1:0] word_index;
        logic [15:0]       data_word;
        logic              last;
    } frame_result_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_CRC,
        FAULT_TYPE,
        FAULT_SIZE,
        FAULT_HEAD,
        FAULT_TAIL
    } frame_fault_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic              frame_found;
    logic [7:0]        frame_address;
    logic              has_word;
    logic [WIDX_W-1:0] word_index;
    logic [15:0]       data_word;
    logic              last;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    // predictor state: its own copy of the byte ring and word count
    logic [7:0]         ring [RING_DEPTH];
    logic [RING_AW-1:0] wr_ptr;
    logic [CFG_W-1:0]   word_count_m;

    frame_result_t frame_results_q [$];
    logic [7:0]    rx_bytes_q [$];
    int            bytes_pushed;
    int            bytes_accepted;
    int            mismatch_cnt;
    int            send_idle_pct;
    int            stall_pct;
    logic          in_taken;

    sliding_window_frame_detector_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_found  (frame_found),
        .frame_address(frame_address),
        .has_word     (has_word),
        .word_index   (word_index),
        .data_word    (data_word),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("sliding_window_frame_detector_unit verification failed");
        $finish;
    end

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic int words_per_frame();
        return (word_count_m > MAX_WORDS) ? MAX_WORDS : int'(word_count_m);
    endfunction

    // byte j of a frame of fsize bytes that ends at the newest ring entry
    function automatic logic [7:0] window_byte(int fsize, int j);
        logic [RING_AW-1:0] pos;
        pos = RING_AW'(int'(wr_ptr) - fsize + j);
        return ring[pos];
    endfunction

    function automatic void predict_frame_results(logic [7:0] b);
        frame_result_t r;
        logic [15:0]   crc;
        logic          hit;
        int            n;
        int            fsize;
        ring[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
        n = words_per_frame();
        fsize = FRAME_OVERHEAD + 2 * n;
        hit = window_byte(fsize, 0) == MARKER && window_byte(fsize, 1) == MARKER &&
              window_byte(fsize, POS_SIZE) == 8'(fsize) &&
              window_byte(fsize, fsize - 2) == MARKER &&
              window_byte(fsize, fsize - 1) == MARKER &&
              window_byte(fsize, POS_TYPE) == FRAME_TYPE;
        if (hit)
        begin
            crc = CRC_INIT;
            for (int j = 0; j < fsize - 4; j++)
            begin
                crc = crc16_update(crc, window_byte(fsize, j));
            end
            hit = crc == {window_byte(fsize, fsize - 3), window_byte(fsize, fsize - 4)};
        end
        r = '0;
        r.last = 1'b1;
        if (!hit)
        begin
            frame_results_q.push_back(r);
        end
        else if (n == 0)
        begin
            r.frame_found   = 1'b1;
            r.frame_address = window_byte(fsize, POS_ADDR);
            frame_results_q.push_back(r);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                r.frame_found   = 1'b1;
                r.frame_address = window_byte(fsize, POS_ADDR);
                r.has_word      = 1'b1;
                r.word_index    = WIDX_W'(i);
                r.data_word     = {window_byte(fsize, WORD_BASE + 2 * i + 1),
                                   window_byte(fsize, WORD_BASE + 2 * i)};
                r.last          = (i == n - 1);
                frame_results_q.push_back(r);
            end
        end
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    // monitor: sample both channels, predict on accepted bytes, check results
    always @(posedge clk)
    begin
        frame_result_t got;
        frame_result_t want;
        in_taken = in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_taken)
            begin
                predict_frame_results(rx_byte);
                bytes_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                got = '{frame_found, frame_address, has_word, word_index, data_word, last};
                if (frame_results_q.size() == 0)
                begin
                    note_mismatch($sformatf({"unexpected result at %0t: found=%b addr=%h ",
                        "hw=%b idx=%0d word=%h last=%b"},
                        $realtime, got.frame_found, got.frame_address, got.has_word,
                        got.word_index, got.data_word, got.last));
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    if (got !== want)
                    begin
                        note_mismatch($sformatf({"mismatch at %0t: exp found=%b addr=%h hw=%b ",
                            "idx=%0d word=%h last=%b, got found=%b addr=%h hw=%b idx=%0d ",
                            "word=%h last=%b"}, $realtime,
                            want.frame_found, want.frame_address, want.has_word,
                            want.word_index, want.data_word, want.last,
                            got.frame_found, got.frame_address, got.has_word,
                            got.word_index, got.data_word, got.last));
                    end
                end
            end
        end
    end

    // driver: advance to the next byte once the current transaction is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    rx_byte  <= rx_bytes_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic void send_byte(logic [7:0] b);
        rx_bytes_q.push_back(b);
        bytes_pushed++;
    endfunction

    // fill < 0 gives random words
    function automatic void queue_frame(int n, frame_fault_t fault, logic [7:0] addr,
                                        int fill);
        logic [7:0]  fr [$];
        logic [15:0] crc;
        logic [15:0] w;
        int          fsize;
        fsize = FRAME_OVERHEAD + 2 * n;
        fr = '{MARKER, MARKER, 8'(fsize), addr, FRAME_TYPE};
        for (int k = 0; k < n; k++)
        begin
            if (fill >= 0)
            begin
                w = 16'(fill);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                w = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end
            else
            begin
                w = 16'($urandom);
            end
            fr.push_back(w[7:0]);
            fr.push_back(w[15:8]);
        end
        crc = CRC_INIT;
        foreach (fr[k])
        begin
            crc = crc16_update(crc, fr[k]);
        end
        fr.push_back(crc[7:0]);
        fr.push_back(crc[15:8]);
        fr.push_back(MARKER);
        fr.push_back(MARKER);
        case (fault)
            FAULT_CRC:  fr[fsize - 4 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            FAULT_TYPE: fr[POS_TYPE] ^= 8'($urandom_range(1, 255));
            FAULT_SIZE: fr[POS_SIZE] ^= 8'($urandom_range(1, 255));
            FAULT_HEAD: fr[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            FAULT_TAIL: fr[fsize - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            default:    ;
        endcase
        foreach (fr[k])
        begin
            send_byte(fr[k]);
        end
    endfunction

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 48; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 48; end
            IDLE_BOTH:     begin send_idle_pct = 38; stall_pct = 38; end
            default:       begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // hold until every byte is taken and every result has left
    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_pushed != bytes_accepted || frame_results_q.size() != 0 || in_stall);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_word_count(logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        word_count_m = value;
        @(posedge clk);
    endtask

    // mostly well-formed frames with random content, some broken, some line noise
    task automatic run_traffic(int budget);
        int start;
        int r;
        start = bytes_pushed;
        @(posedge clk);
        while (bytes_pushed - start < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
            begin
                queue_frame(words_per_frame(), FAULT_NONE, 8'($urandom), -1);
            end
            else if (r < 82)
            begin
                queue_frame(words_per_frame(), frame_fault_t'($urandom_range(1, 5)),
                            8'($urandom), -1);
            end
            else if (r < 87)
            begin
                queue_frame($urandom_range(0, 3), FAULT_NONE, 8'($urandom), -1);
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] plan [7];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = 8'h00;
        out_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_taken  = 1'b0;
        bytes_pushed   = 0;
        bytes_accepted = 0;
        mismatch_cnt   = 0;
        foreach (ring[k])
        begin
            ring[k] = RING_FILL;
        end
        wr_ptr       = '0;
        word_count_m = WORD_COUNT_RESET;
        set_idle(IDLE_NONE);
        // the saturating count runs under receiver stalls
        plan = '{CFG_W'(1), CFG_W'(0), CFG_W'(31), CFG_W'(3), CFG_W'(2), CFG_W'(2),
                 CFG_W'(1)};
        plan[4] = CFG_W'($urandom_range(0, 3));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero byte against the 0xFF-filled ring, then an all-ones frame at reset count
        send_byte(8'h00);
        queue_frame(1, FAULT_NONE, 8'hFF, 16'hFFFF);
        wait_drained();
        // frame without data words
        write_word_count(CFG_W'(0));
        queue_frame(0, FAULT_NONE, 8'h00, 0);
        wait_drained();

        for (int p = 0; p < 7; p++)
        begin
            set_idle(idle_mode_t'(p % 4));
            write_word_count(plan[p]);
            run_traffic(8);
            wait_drained();
        end

        repeat (120) @(negedge clk);
        if (mismatch_cnt == 0 && frame_results_q.size() == 0)
        begin
            $display("sliding_window_frame_detector_unit verification clean");
        end
        else
        begin
            $display("sliding_window_frame_detector_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/swfd_pkg.sv
rtl/core/swfd_ram.sv
rtl/core/swfd_crc_unit.sv
rtl/core/sliding_window_frame_detector_unit.sv
verif/sliding_window_frame_detector_unit_tb.sv
